@@ hw/rtl/tte_pkg.sv @@
// Shared types, codes and sizes for the token expiry table.
`default_nettype none
package tte_pkg;

  localparam int unsigned Entries = 16;
  localparam int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned LiveW   = 5;
  localparam int unsigned CntW    = ($clog2(Entries + 1) > LiveW) ? $clog2(Entries + 1) : LiveW;
  localparam int unsigned TtlW    = 24;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned KeyW    = 32;

  // operation codes
  localparam logic [1:0] OpGenerate = 2'd0;
  localparam logic [1:0] OpRenew    = 2'd1;
  localparam logic [1:0] OpCount    = 2'd2;

  // status codes
  localparam logic [1:0] StDone        = 2'd0;
  localparam logic [1:0] StRenewIgnore = 2'd1;
  localparam logic [1:0] StTableFull   = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [KeyW-1:0]  token_key;
    logic [TimeW-1:0] current_time;
  } tte_req_t;

  typedef struct packed {
    logic [LiveW-1:0] live_count;
    logic [1:0]       status;
  } tte_rsp_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] expiry;
  } tte_entry_t;

  typedef struct packed {
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    tte_entry_t      wr_data;
  } tte_ram_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/tte_ram.sv @@
// Key and expiry storage: one write port, one registered read port.
`default_nettype none
module tte_ram (
  input  wire logic                  clk_i,
  input  wire tte_pkg::tte_ram_ctl_t ctl_i,
  output tte_pkg::tte_entry_t        rdata_o
);
  import tte_pkg::*;

  tte_entry_t mem [Entries];
  tte_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[ctl_i.wr_addr] <= ctl_i.wr_data;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[ctl_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ hw/rtl/tte_engine.sv @@
// Request sequencer: scans the table to expire, match and count, then writes back.
`default_nettype none
module tte_engine (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      req_valid_i,
  output logic                           req_stall_o,
  input  wire tte_pkg::tte_req_t         req_i,
  input  wire logic [tte_pkg::TtlW-1:0]  ttl_i,
  output logic                           rsp_valid_o,
  input  wire logic                      rsp_ready_i,
  output tte_pkg::tte_rsp_t              rsp_o,
  output tte_pkg::tte_ram_ctl_t          ram_o,
  input  wire tte_pkg::tte_entry_t       ram_rdata_i
);
  import tte_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [Entries-1:0] valid_q, valid_d;
  logic [IdxW:0]      iss_q, iss_d;
  logic               chk_v_q, chk_v_d;
  logic [IdxW-1:0]    chk_idx_q, chk_idx_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               match_q, match_d;
  logic [IdxW-1:0]    match_idx_q, match_idx_d;
  logic               free_q, free_d;
  logic [IdxW-1:0]    free_idx_q, free_idx_d;
  tte_req_t           req_q, req_d;
  tte_rsp_t           rsp_q, rsp_d;

  logic [TtlW-1:0]    life;
  logic [TimeW:0]     exp_sum;
  logic [TimeW-1:0]   exp_new;
  logic               accept;

  assign accept      = req_valid_i && (state_q == S_IDLE);
  assign req_stall_o = (state_q != S_IDLE);
  assign rsp_valid_o = (state_q == S_DONE);
  assign rsp_o       = rsp_q;

  // zero ttl behaves as one; expiry saturates at the top time
  assign life    = (ttl_i == '0) ? TtlW'(1) : ttl_i;
  assign exp_sum = {1'b0, req_q.current_time} + {{(TimeW + 1 - TtlW){1'b0}}, life};
  assign exp_new = exp_sum[TimeW] ? '1 : exp_sum[TimeW-1:0];

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    iss_d       = iss_q;
    chk_v_d     = 1'b0;
    chk_idx_d   = chk_idx_q;
    cnt_d       = cnt_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    req_d       = req_q;
    rsp_d       = rsp_q;
    ram_o       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d   = req_i;
          iss_d   = '0;
          cnt_d   = '0;
          match_d = 1'b0;
          free_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (iss_q != (IdxW + 1)'(Entries)) begin
          ram_o.rd_en   = 1'b1;
          ram_o.rd_addr = iss_q[IdxW-1:0];
          chk_v_d       = 1'b1;
          chk_idx_d     = iss_q[IdxW-1:0];
          iss_d         = iss_q + (IdxW + 1)'(1);
        end
        if (chk_v_q) begin
          if (valid_q[chk_idx_q] && (ram_rdata_i.expiry > req_q.current_time)) begin
            cnt_d = cnt_q + CntW'(1);
            if (ram_rdata_i.key == req_q.token_key) begin
              match_d     = 1'b1;
              match_idx_d = chk_idx_q;
            end
          end else begin
            valid_d[chk_idx_q] = 1'b0;
            if (!free_q) begin
              free_d     = 1'b1;
              free_idx_d = chk_idx_q;
            end
          end
          if (chk_idx_q == IdxW'(Entries - 1)) begin
            state_d = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        rsp_d.status        = StDone;
        ram_o.wr_data.key    = req_q.token_key;
        ram_o.wr_data.expiry = exp_new;
        case (req_q.operation)
          OpGenerate: begin
            if (match_q) begin
              ram_o.wr_en   = 1'b1;
              ram_o.wr_addr = match_idx_q;
            end else if (free_q) begin
              ram_o.wr_en         = 1'b1;
              ram_o.wr_addr       = free_idx_q;
              valid_d[free_idx_q] = 1'b1;
              cnt_d               = cnt_q + CntW'(1);
            end else begin
              rsp_d.status = StTableFull;
            end
          end
          OpRenew: begin
            if (match_q) begin
              ram_o.wr_en   = 1'b1;
              ram_o.wr_addr = match_idx_q;
            end else begin
              rsp_d.status = StRenewIgnore;
            end
          end
          default: begin
          end
        endcase
        rsp_d.live_count = cnt_d[LiveW-1:0];
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      iss_q   <= '0;
      chk_v_q <= 1'b0;
      cnt_q   <= '0;
      match_q <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      iss_q   <= iss_d;
      chk_v_q <= chk_v_d;
      cnt_q   <= cnt_d;
      match_q <= match_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q   <= chk_idx_d;
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    req_q       <= req_d;
    rsp_q       <= rsp_d;
  end

endmodule
`default_nettype wire

@@ hw/rtl/ttl_token_expiry_table.sv @@
// Token expiry table top level: ttl register, engine, storage and result register.
// A table of Entries token keys, each with an expiry time, held in a
// single-port-write, registered-read RAM with valid bits in flops. Each
// request walks the whole table once, one entry per cycle through the RAM
// read port, dropping entries whose expiry is at or before the request's
// time, looking for the key and counting live entries; a write state then
// writes the refreshed or new entry back, if there is one. No new request
// is taken until the engine has handed its result on, which waits while a
// stalled result still fills the output register. The ttl register is
// written through its own valid/ready port, always ready, and should only
// be changed while no request is in flight.
`default_nettype none
module ttl_token_expiry_table (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire tte_pkg::tte_req_t         in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output tte_pkg::tte_rsp_t              out_data_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [tte_pkg::TtlW-1:0]  cfg_data_i
);
  import tte_pkg::*;

  logic [TtlW-1:0] ttl_q;
  logic            out_valid_q, out_valid_d;
  tte_rsp_t        out_data_q;
  logic            rsp_valid, rsp_ready;
  tte_rsp_t        rsp;
  tte_ram_ctl_t    ram_ctl;
  tte_entry_t      ram_rdata;

  assign cfg_ready_o = 1'b1;

  tte_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_stall_o (in_stall_o),
    .req_i       (in_data_i),
    .ttl_i       (ttl_q),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp),
    .ram_o       (ram_ctl),
    .ram_rdata_i (ram_rdata)
  );

  tte_ram u_ram (
    .clk_i   (clk_i),
    .ctl_i   (ram_ctl),
    .rdata_o (ram_rdata)
  );

  // result register frees the engine while the consumer stalls
  assign rsp_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_valid && rsp_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q       <= TtlW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        ttl_q <= cfg_data_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && rsp_ready) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a request taken keeps the input stalled for the scan
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after request accepted");

  // engine cannot hold a finished result and take a new request
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> in_stall_o)
    else $error("input open while result pending in engine");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(out_data_o.live_count) <= Entries))
    else $error("live count above table size");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == StDone || out_data_o.status == StRenewIgnore ||
                     out_data_o.status == StTableFull))
    else $error("unknown status code");

endmodule
`default_nettype wire

@@ test/ttl_token_expiry_table_tb.sv @@
// Self-checking testbench for the token expiry table: directed and random request streams.
`timescale 1ns / 100ps
module ttl_token_expiry_table_tb;
  import tte_pkg::*;

  localparam logic [1:0] OpUnused      = 2'd3;
  localparam int unsigned CfgSettle    = 24;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned KeyPool      = 24;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  tte_req_t in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  tte_rsp_t out_data_o;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  logic [TtlW-1:0] cfg_data_i;

  ttl_token_expiry_table u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow copy of the table
  logic             tbl_live [Entries];
  logic [KeyW-1:0]  tbl_key  [Entries];
  logic [TimeW-1:0] tbl_exp  [Entries];
  logic [TtlW-1:0]  ttl_q;

  tte_rsp_t    live_status_q [$];
  tte_rsp_t    exp_rsp;
  int unsigned fail_cnt    = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;
  int unsigned gap_max     = 0;
  int unsigned stall_pct   = 0;
  int unsigned stall_max   = 0;
  int unsigned stall_run   = 0;
  bit          req_held    = 1'b0;

  function automatic tte_rsp_t apply_token_req(input tte_req_t req);
    tte_rsp_t         rsp;
    int               slot;
    int               i;
    int unsigned      live;
    logic [TimeW:0]   sum;
    logic [TimeW-1:0] new_exp;
    rsp.status = StDone;
    slot = -1;
    live = 0;
    sum = {1'b0, req.current_time} + ((ttl_q == '0) ? 33'd1 : {9'd0, ttl_q});
    new_exp = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
    for (i = 0; i < Entries; i++)
      if (tbl_live[i] && tbl_exp[i] <= req.current_time) tbl_live[i] = 1'b0;
    if (req.operation == OpGenerate || req.operation == OpRenew)
      for (i = 0; i < Entries; i++)
        if (slot < 0 && tbl_live[i] && tbl_key[i] == req.token_key) slot = i;
    if (req.operation == OpGenerate) begin
      for (i = 0; i < Entries; i++)
        if (slot < 0 && !tbl_live[i]) slot = i;
      if (slot < 0) begin
        rsp.status = StTableFull;
      end else begin
        tbl_live[slot] = 1'b1;
        tbl_key[slot]  = req.token_key;
        tbl_exp[slot]  = new_exp;
      end
    end else if (req.operation == OpRenew) begin
      if (slot < 0) rsp.status = StRenewIgnore;
      else tbl_exp[slot] = new_exp;
    end
    for (i = 0; i < Entries; i++)
      if (tbl_live[i]) live++;
    rsp.live_count = LiveW'(live);
    return rsp;
  endfunction

  function automatic tte_req_t mk_req(input logic [1:0] op, input logic [KeyW-1:0] key,
                                      input logic [TimeW-1:0] t);
    tte_req_t req;
    req.operation    = op;
    req.token_key    = key;
    req.current_time = t;
    return req;
  endfunction

  // valid stays up across a burst; a gap lowers it once
  task automatic send_req(input tte_req_t req);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    req_held = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    live_status_q.insert(live_status_q.size(), apply_token_req(req));
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (gap_max != 0) begin
        in_valid_i <= 1'b0;
        req_held = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic quiesce();
    if (req_held) in_valid_i <= 1'b0;
    req_held = 1'b0;
    while (live_status_q.size() != 0) @(posedge clk_i);
    repeat (CfgSettle) @(posedge clk_i);
  endtask

  task automatic write_ttl(input logic [TtlW-1:0] value);
    quiesce();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    ttl_q = value;
    cfg_valid_i <= 1'b0;
  endtask

  // default ttl of 1, expiry at or before the request time, unused code
  task automatic test_reset_ttl();
    gap_max = 3; stall_pct = 20; stall_max = 4;
    send_req(mk_req(OpGenerate, 32'h0000_0000, 32'd0));
    send_req(mk_req(OpCount,    32'hFFFF_FFFF, 32'd0));
    send_req(mk_req(OpRenew,    32'h0000_0000, 32'd1));
    send_req(mk_req(OpUnused,   32'h1234_5678, 32'd1));
  endtask

  task automatic test_table_full();
    int i;
    write_ttl({TtlW{1'b1}});
    gap_max = 0; stall_pct = 0;
    for (i = 0; i < Entries - 1; i++) send_req(mk_req(OpGenerate, 32'h10 + i, 32'd100));
    send_req(mk_req(OpGenerate, 32'hFFFF_FFFF, 32'd100));
    send_req(mk_req(OpGenerate, 32'hDEAD_BEEF, 32'd100));
    send_req(mk_req(OpGenerate, 32'h0000_0012, 32'd200));
    send_req(mk_req(OpRenew,    32'hFFFF_FFFF, 32'd300));
  endtask

  // saturating expiry, then time running backwards
  task automatic test_saturation();
    gap_max = 5; stall_pct = 40; stall_max = 10;
    send_req(mk_req(OpGenerate, 32'hA5A5_A5A5, 32'hFFFF_FFF0));
    send_req(mk_req(OpCount,    32'h0,         32'h0000_0000));
    send_req(mk_req(OpCount,    32'h0,         32'hFFFF_FFFF));
  endtask

  task automatic test_zero_ttl();
    write_ttl('0);
    gap_max = 2; stall_pct = 10; stall_max = 2;
    send_req(mk_req(OpGenerate, 32'h5A5A_5A5A, 32'd10));
    send_req(mk_req(OpCount,    32'h0,         32'd10));
    send_req(mk_req(OpCount,    32'h0,         32'd11));
  endtask

  task automatic run_random_phase(input logic [TtlW-1:0] ttl_val, input int unsigned n_items);
    logic [KeyW-1:0]  pool [KeyPool];
    logic [TimeW-1:0] now;
    int unsigned      life;
    int unsigned      step_max;
    int unsigned      pick;
    tte_req_t         req;
    write_ttl(ttl_val);
    foreach (pool[i]) pool[i] = $urandom;
    life = (ttl_val == '0) ? 32'd1 : {8'd0, ttl_val};
    step_max = (life >> 3) + 1;
    now = $urandom;
    if ($urandom_range(0, 3) == 0) now = 32'hFFFF_FFFF - $urandom_range(0, life);
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) now = now - $urandom_range(0, step_max * 4);
      else if (pick < 8) now = now + $urandom_range(0, life * 3);
      else now = now + $urandom_range(0, step_max);
      pick = $urandom_range(0, 99);
      if (pick < 45) req.operation = OpGenerate;
      else if (pick < 75) req.operation = OpRenew;
      else if (pick < 92) req.operation = OpCount;
      else req.operation = OpUnused;
      req.token_key = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, KeyPool-1)];
      req.current_time = now;
      send_req(req);
    end
  endtask

  task automatic test_random();
    gap_max = 0;  stall_pct = 0;  stall_max = 0;
    run_random_phase(24'd1, 75);
    gap_max = 6;  stall_pct = 30; stall_max = 8;
    run_random_phase({TtlW{1'b1}}, 75);
    gap_max = 12; stall_pct = 10; stall_max = 40;
    run_random_phase(24'd3, 75);
    gap_max = 2;  stall_pct = 50; stall_max = 3;
    run_random_phase(24'd40, 75);
    gap_max = 4;  stall_pct = 0;  stall_max = 0;
    run_random_phase(TtlW'($urandom_range(1, 24'hFFFFFF)), 75);
    gap_max = 0;  stall_pct = 25; stall_max = 20;
    run_random_phase(TtlW'($urandom_range(1, 4096)), 75);
  endtask

  // result checking, receiver stall pattern and activity tracking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (live_status_q.size() == 0) begin
        $error("unexpected result: live_count %0d status %0d",
               out_data_o.live_count, out_data_o.status);
        fail_cnt++;
      end else begin
        exp_rsp = live_status_q[0];
        live_status_q.delete(0);
        if (out_data_o.live_count !== exp_rsp.live_count) begin
          $error("live_count mismatch: expected %0d, actual %0d",
                 exp_rsp.live_count, out_data_o.live_count);
          fail_cnt++;
        end
        if (out_data_o.status !== exp_rsp.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 exp_rsp.status, out_data_o.status);
          fail_cnt++;
        end
      end
    end
    if (stall_run != 0) begin
      out_stall_i <= 1'b1;
      stall_run   <= stall_run - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_run   <= $urandom_range(0, stall_max);
    end else begin
      out_stall_i <= 1'b0;
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    ttl_q = 24'd1;
    foreach (tbl_live[i]) begin
      tbl_live[i] = 1'b0;
      tbl_key[i]  = '0;
      tbl_exp[i]  = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_ttl();
    test_table_full();
    test_saturation();
    test_zero_ttl();
    test_random();
    quiesce();
    if (fail_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/tte_pkg.sv
hw/rtl/tte_ram.sv
hw/rtl/tte_engine.sv
hw/rtl/ttl_token_expiry_table.sv
test/ttl_token_expiry_table_tb.sv
